@@ design/wssl_pkg.sv @@
// Shared types, codes and helper functions for the weekly setpoint schedule lookup.
package wssl_pkg;

  // Item kind carried on the input tuser
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Week mode register codes
  localparam logic [1:0] MODE_SAME_EVERY_DAY = 2'd0;
  localparam logic [1:0] MODE_FIVE_PLUS_TWO  = 2'd1;
  localparam logic [1:0] MODE_SIX_PLUS_ONE   = 2'd2;

  // Weekday codes used by the set selection
  localparam logic [2:0] DAY_SUNDAY   = 3'd0;
  localparam logic [2:0] DAY_SATURDAY = 3'd6;
  localparam logic [2:0] DAY_INVALID  = 3'd7;

  // Field widths of one stored entry
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int TEMP_W  = 8;
  localparam int KEY_W   = HOUR_W + MIN_W;
  localparam int ENTRY_W = KEY_W + TEMP_W;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [TEMP_W-1:0]  temp_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  // Lookup sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_YDAY,
    S_DONE
  } state_t;

  // True when the given day is served by the weekend set
  function automatic logic use_weekend(input logic [1:0] mode, input logic [2:0] day);
    logic r;
    r = 1'b0;
    if (mode == MODE_FIVE_PLUS_TWO && (day == DAY_SATURDAY || day == DAY_SUNDAY)) begin
      r = 1'b1;
    end else if (mode == MODE_SIX_PLUS_ONE && day == DAY_SUNDAY) begin
      r = 1'b1;
    end
    return r;
  endfunction

  // Previous weekday; Sunday and the invalid day both wrap to Saturday
  function automatic logic [2:0] prev_day(input logic [2:0] day);
    logic [2:0] r;
    if (day == DAY_SUNDAY || day == DAY_INVALID) begin
      r = DAY_SATURDAY;
    end else begin
      r = day - 3'd1;
    end
    return r;
  endfunction

  // Entry layout: {hour, minute, temperature}
  function automatic entry_t pack_entry(input logic [HOUR_W-1:0] h, input logic [MIN_W-1:0] m,
                                        input temp_t t);
    return {h, m, t};
  endfunction

  function automatic key_t entry_key(input entry_t e);
    return e[ENTRY_W-1:TEMP_W];
  endfunction

  function automatic temp_t entry_temp(input entry_t e);
    return e[TEMP_W-1:0];
  endfunction

endpackage

@@ design/wssl_entry_mem.sv @@
// Schedule entry memory: one write port, one read port with registered read data.
module wssl_entry_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  wssl_pkg::entry_t       wr_data,
  input  logic [AW-1:0]          rd_addr,
  output wssl_pkg::entry_t       rd_data
);

  wssl_pkg::entry_t mem [DEPTH];
  wssl_pkg::entry_t rd_data_r;

  // Write one entry, read one entry every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/weekly_setpoint_schedule_lookup.sv @@
// Top level of the weekly setpoint schedule lookup: sequencer, registers and entry memory.
//
// Usage: the in_ channel carries schedule writes (in_tuser = 0) and setpoint
// queries (in_tuser = 1). A write stores one entry of the workday or weekend
// set in the cycle it is accepted and gives no result. A query walks the set
// chosen for its weekday in the entry memory and returns one transaction on
// the out_ channel: the setpoint in half degrees and a flag that marks a value
// taken from the previous day's last entry.
// The cfg_ channel writes the 2-bit week mode; it is always ready.
// Sequence: a write is stored when it is accepted. A query reads one entry per cycle from the
// memory: the first entry at acceptance, then up to SLOTS-1 more for the scan
// or one for the previous day, then it loads the result into the output register,
// which raises out_tvalid. One item is in work at a time: in_tready is high
// only while the sequencer is idle, so the next item waits until a query is done.
// Stall: the result sits in the output register until out_tready; the next
// item may be accepted meanwhile, and a further query result waits in the
// sequencer until the output register frees up.
// Reset: rst_n (synchronous, active low) clears the sequencer, the output
// valid and the week mode. Entries are undefined until written; software
// writes every entry of a set, in ascending time order, before querying it.
module weekly_setpoint_schedule_lookup #(
  parameter int SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: week mode
  input  logic        cfg_tvalid,
  output logic        cfg_tready,
  input  logic [1:0]  cfg_tdata,   // [1:0] week_mode
  // Input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [0] set_select, [4:1] slot, [9:5] hour, [15:10] minute,
                                   // [18:16] weekday, [26:19] temperature_in, [31:27] zero
  input  logic        in_tuser,    // [0] kind
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] setpoint
  output logic        out_tuser    // [0] from_yesterday
);

  localparam int DEPTH = 2 * SLOTS;
  localparam int RW    = $clog2(DEPTH);
  localparam int IW    = $clog2(SLOTS);
  localparam logic [RW-1:0] WEEKEND_BASE = RW'(SLOTS);
  localparam logic [RW-1:0] LAST_OFS     = RW'(SLOTS - 1);
  localparam logic [IW-1:0] LAST_IDX     = IW'(SLOTS - 1);

  // Memory write request
  typedef struct packed {
    logic                 en;
    logic [RW-1:0]        addr;
    wssl_pkg::entry_t     data;
  } wr_req_t;

  // Input field split
  logic                    f_set_select;
  logic [3:0]              f_slot;
  logic [4:0]              f_hour;
  logic [5:0]              f_minute;
  logic [2:0]              f_weekday;
  wssl_pkg::temp_t         f_temp;

  assign f_set_select = in_tdata[0];
  assign f_slot       = in_tdata[4:1];
  assign f_hour       = in_tdata[9:5];
  assign f_minute     = in_tdata[15:10];
  assign f_weekday    = in_tdata[18:16];
  assign f_temp       = in_tdata[26:19];

  wssl_pkg::state_t        state_r, state_nxt;
  logic [1:0]              week_mode_r;
  wssl_pkg::key_t          qkey_r, qkey_nxt;
  logic                    weekend_r, weekend_nxt;
  logic                    yday_weekend_r, yday_weekend_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic                    prev_le_r, prev_le_nxt;
  wssl_pkg::temp_t         prev_temp_r, prev_temp_nxt;
  wssl_pkg::temp_t         res_temp_r, res_temp_nxt;
  logic                    res_yday_r, res_yday_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  wssl_pkg::temp_t         out_temp_r, out_temp_nxt;
  logic                    out_yday_r, out_yday_nxt;

  logic                    in_xact;
  logic                    out_free;
  logic [RW-1:0]           rd_addr;
  wssl_pkg::entry_t        rd_data;
  wr_req_t                 wr_req;
  logic [RW-1:0]           base;
  logic [RW-1:0]           yday_base;
  logic                    in_weekend;
  wssl_pkg::key_t          rd_key;

  assign in_tready  = (state_r == wssl_pkg::S_IDLE);
  assign cfg_tready = 1'b1;
  assign in_xact    = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign base       = weekend_r ? WEEKEND_BASE : '0;
  assign yday_base  = yday_weekend_r ? WEEKEND_BASE : '0;
  assign in_weekend = wssl_pkg::use_weekend(week_mode_r, f_weekday);
  assign rd_key     = wssl_pkg::entry_key(rd_data);

  // Store an entry on an accepted write transaction with an in-range slot
  always_comb begin
    wr_req.en   = in_xact && (in_tuser == wssl_pkg::KIND_WRITE) && (32'(f_slot) < SLOTS);
    wr_req.addr = (f_set_select ? WEEKEND_BASE : '0) + RW'(f_slot);
    wr_req.data = wssl_pkg::pack_entry(f_hour, f_minute, f_temp);
  end

  wssl_entry_mem #(
    .DEPTH (DEPTH),
    .AW    (RW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_req.en),
    .wr_addr (wr_req.addr),
    .wr_data (wr_req.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: next state, read address and working registers
  always_comb begin
    state_nxt        = state_r;
    qkey_nxt         = qkey_r;
    weekend_nxt      = weekend_r;
    yday_weekend_nxt = yday_weekend_r;
    idx_nxt          = idx_r;
    prev_le_nxt      = prev_le_r;
    prev_temp_nxt    = prev_temp_r;
    res_temp_nxt     = res_temp_r;
    res_yday_nxt     = res_yday_r;
    out_tvalid_nxt   = out_tvalid_r && !out_tready;
    out_temp_nxt     = out_temp_r;
    out_yday_nxt     = out_yday_r;
    rd_addr          = base;

    unique case (state_r)
      wssl_pkg::S_IDLE: begin
        // Latch the query and fetch the first entry of the day's set
        rd_addr = in_weekend ? WEEKEND_BASE : '0;
        if (in_xact && in_tuser == wssl_pkg::KIND_QUERY) begin
          qkey_nxt         = {f_hour, f_minute};
          weekend_nxt      = in_weekend;
          yday_weekend_nxt = wssl_pkg::use_weekend(week_mode_r,
                                                   wssl_pkg::prev_day(f_weekday));
          state_nxt        = wssl_pkg::S_FIRST;
        end
      end
      wssl_pkg::S_FIRST: begin
        // Before the first entry: take yesterday's last entry, else start the scan
        if (qkey_r < rd_key) begin
          rd_addr   = yday_base + LAST_OFS;
          state_nxt = wssl_pkg::S_YDAY;
        end else begin
          prev_le_nxt   = 1'b1;
          prev_temp_nxt = wssl_pkg::entry_temp(rd_data);
          idx_nxt       = IW'(1);
          rd_addr       = base + RW'(1);
          state_nxt     = wssl_pkg::S_SCAN;
        end
      end
      wssl_pkg::S_SCAN: begin
        // Entry idx is on the read port; compare it with the previous one
        if (prev_le_r && rd_key > qkey_r) begin
          res_temp_nxt = prev_temp_r;
          res_yday_nxt = 1'b0;
          state_nxt    = wssl_pkg::S_DONE;
        end else if (idx_r == LAST_IDX) begin
          res_temp_nxt = wssl_pkg::entry_temp(rd_data);
          res_yday_nxt = 1'b0;
          state_nxt    = wssl_pkg::S_DONE;
        end else begin
          prev_le_nxt   = (rd_key <= qkey_r);
          prev_temp_nxt = wssl_pkg::entry_temp(rd_data);
          idx_nxt       = idx_r + IW'(1);
          rd_addr       = base + RW'(idx_r) + RW'(1);
        end
      end
      wssl_pkg::S_YDAY: begin
        res_temp_nxt = wssl_pkg::entry_temp(rd_data);
        res_yday_nxt = 1'b1;
        state_nxt    = wssl_pkg::S_DONE;
      end
      wssl_pkg::S_DONE: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_temp_nxt   = res_temp_r;
          out_yday_nxt   = res_yday_r;
          state_nxt      = wssl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = wssl_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= wssl_pkg::S_IDLE;
      out_tvalid_r <= 1'b0;
      week_mode_r  <= wssl_pkg::MODE_SAME_EVERY_DAY;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_tvalid && cfg_tready) begin
        week_mode_r <= cfg_tdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    qkey_r         <= qkey_nxt;
    weekend_r      <= weekend_nxt;
    yday_weekend_r <= yday_weekend_nxt;
    idx_r          <= idx_nxt;
    prev_le_r      <= prev_le_nxt;
    prev_temp_r    <= prev_temp_nxt;
    res_temp_r     <= res_temp_nxt;
    res_yday_r     <= res_yday_nxt;
    out_temp_r     <= out_temp_nxt;
    out_yday_r     <= out_yday_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_temp_r;
  assign out_tuser  = out_yday_r;

  // An accepted query starts the lookup on the next cycle
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xact && in_tuser == wssl_pkg::KIND_QUERY |=> state_r == wssl_pkg::S_FIRST)
    else $error("query transaction did not start the lookup");

  // A write transaction never leaves the sequencer busy
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xact && in_tuser == wssl_pkg::KIND_WRITE |=> state_r == wssl_pkg::S_IDLE)
    else $error("write transaction left the sequencer busy");

  // The scan index stays past the first entry
  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wssl_pkg::S_SCAN |-> idx_r != '0)
    else $error("scan index out of range");

  // A previous-day read always finishes as a flagged result
  a_yday_flag: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wssl_pkg::S_YDAY |=> state_r == wssl_pkg::S_DONE && res_yday_r)
    else $error("previous-day result lost its flag");

  // A finished result reaches the output register when it is free
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == wssl_pkg::S_DONE && out_free |=> out_tvalid_r && state_r == wssl_pkg::S_IDLE)
    else $error("finished result not presented");

endmodule
